/* hdl/racu_pkg.sv */
package racu_pkg;

   localparam int SEGMENTS = 64;

   localparam int LOAD_W = 16;
   localparam int STN_W  = 7;
   localparam int LIDX_W = 6;
   // wide enough for any station code and any segment position
   localparam int CMP_W  = 11;
   localparam int CNT_W  = $clog2(SEGMENTS + 1);

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_BOOK = 1'b1;

   typedef struct packed {
      logic              write_en;
      logic              add_en;
      logic [STN_W-1:0]  start_stn;
      logic [STN_W-1:0]  end_stn;
      logic [LIDX_W-1:0] load_index;
      logic [LOAD_W-1:0] load_value;
      logic [LOAD_W-1:0] amount;
   } cell_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

endpackage

/* hdl/racu_cell.sv */
module racu_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [racu_pkg::CMP_W-1:0]  cell_pos,
   input  racu_pkg::cell_ctl_type      ctl,
   input  logic [racu_pkg::LOAD_W-1:0] max_in,
   output logic [racu_pkg::LOAD_W-1:0] max_out
);
   import racu_pkg::*;

   logic [LOAD_W-1:0] load_ff;
   logic [LOAD_W-1:0] load_in;
   logic [LOAD_W-1:0] max_ff;
   logic [LOAD_W-1:0] max_in_val;
   logic              in_range;
   logic              idx_hit;

   assign in_range = (cell_pos >= CMP_W'(ctl.start_stn)) && (cell_pos < CMP_W'(ctl.end_stn));
   assign idx_hit  = (cell_pos == CMP_W'(ctl.load_index));

   always_comb begin
      load_in = load_ff;
      if (ctl.write_en && idx_hit) begin
         load_in = ctl.load_value;
      end else if (ctl.add_en && in_range) begin
         load_in = LOAD_W'(load_ff + ctl.amount);
      end
   end

   // running max moves one cell per cycle
   always_comb begin
      max_in_val = max_in;
      if (in_range && (load_ff > max_in)) begin
         max_in_val = load_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
      end else begin
         load_ff <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in_val;
   end

   assign max_out = max_ff;

endmodule

/* hdl/racu_ctrl.sv */
module racu_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_func,
   input  logic [racu_pkg::LIDX_W-1:0] req_load_index,
   input  logic [racu_pkg::LOAD_W-1:0] req_load_value,
   input  logic [racu_pkg::STN_W-1:0]  req_start_station,
   input  logic [racu_pkg::STN_W-1:0]  req_end_station,
   input  logic [racu_pkg::LOAD_W-1:0] req_amount,
   input  logic                        csr_wr_en,
   input  logic [racu_pkg::LOAD_W-1:0] csr_wr_data,
   input  logic [racu_pkg::LOAD_W-1:0] max_last,
   output racu_pkg::cell_ctl_type      cell_ctl,
   output logic                        rsp_strobe,
   output logic                        rsp_accepted
);
   import racu_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LOAD_W-1:0] cap_ff;
   logic              func_ff;
   logic [LIDX_W-1:0] lidx_ff;
   logic [LOAD_W-1:0] lval_ff;
   logic [STN_W-1:0]  stn_lo_ff;
   logic [STN_W-1:0]  stn_hi_ff;
   logic [LOAD_W-1:0] amount_ff;
   logic              strobe_ff, strobe_in;
   logic              acc_ff, acc_in;
   logic              accept;
   logic              in_bounds;
   logic              grant;

   assign accept    = start && (state_ff == ST_IDLE);
   assign in_bounds = CMP_W'(lidx_ff) < CMP_W'(SEGMENTS);
   assign grant     = (max_last <= cap_ff) && ((cap_ff - max_last) >= amount_ff);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      acc_in    = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = (req_func == FUNC_LOAD) ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: begin
            strobe_in = 1'b1;
            acc_in    = in_bounds;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            cnt_in = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(SEGMENTS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            strobe_in = 1'b1;
            acc_in    = grant;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
         acc_ff    <= 1'b0;
         cap_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
         acc_ff    <= acc_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         lidx_ff   <= req_load_index;
         lval_ff   <= req_load_value;
         stn_lo_ff <= req_start_station;
         stn_hi_ff <= req_end_station;
         amount_ff <= req_amount;
      end
   end

   always_comb begin
      cell_ctl.write_en   = (state_ff == ST_LOAD) && (func_ff == FUNC_LOAD);
      cell_ctl.add_en     = (state_ff == ST_DECIDE) && (func_ff == FUNC_BOOK) && grant;
      cell_ctl.start_stn  = stn_lo_ff;
      cell_ctl.end_stn    = stn_hi_ff;
      cell_ctl.load_index = lidx_ff;
      cell_ctl.load_value = lval_ff;
      cell_ctl.amount     = amount_ff;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_accepted = acc_ff;

endmodule

/* hdl/range_capacity_admission_unit.sv */
// Seat admission over a row of route segments, one cell per segment. An item
// is taken when start is high and busy is low. A load item (func 0) passes
// through the load state and returns its registered result; a booking
// (func 1) passes through the scan and decide states, its time set by the
// running maximum that walks the cell row one cell per cycle before the
// grant decision, after which the add is applied to all cells in the range
// at once. busy is low again in the cycle the result strobe shows, so the
// next item can be taken then. rsp_strobe is high for one cycle per item and
// cannot be held off; capture rsp_accepted in that cycle. Write capacity
// only while busy is low and no result is pending.
module range_capacity_admission_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_func,
   input  logic [racu_pkg::LIDX_W-1:0] req_load_index,
   input  logic [racu_pkg::LOAD_W-1:0] req_load_value,
   input  logic [racu_pkg::STN_W-1:0]  req_start_station,
   input  logic [racu_pkg::STN_W-1:0]  req_end_station,
   input  logic [racu_pkg::LOAD_W-1:0] req_amount,
   input  logic                        csr_wr_en,
   input  logic [racu_pkg::LOAD_W-1:0] csr_wr_data,
   output logic                        rsp_strobe,
   output logic                        rsp_accepted
);
   import racu_pkg::*;

   cell_ctl_type      cell_ctl;
   logic [LOAD_W-1:0] max_chain [SEGMENTS+1];

   assign max_chain[0] = '0;

   racu_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_load_index    (req_load_index),
      .req_load_value    (req_load_value),
      .req_start_station (req_start_station),
      .req_end_station   (req_end_station),
      .req_amount        (req_amount),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .max_last          (max_chain[SEGMENTS]),
      .cell_ctl          (cell_ctl),
      .rsp_strobe        (rsp_strobe),
      .rsp_accepted      (rsp_accepted)
   );

   for (genvar i = 0; i < SEGMENTS; i++) begin : g_cell
      racu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_pos (CMP_W'(i)),
         .ctl      (cell_ctl),
         .max_in   (max_chain[i]),
         .max_out  (max_chain[i+1])
      );
   end

endmodule

/* hdl/racu_checker.sv */
module racu_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // one beat per item, never back to back
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two cycles in a row");

   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("busy not raised after an item was taken");

   // a taken item's result strobe comes no earlier than after its load or scan state
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> !rsp_strobe)
      else $error("result one cycle after the item was taken");

   assert property (@(posedge clock) reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

endmodule

bind range_capacity_admission_unit racu_checker u_racu_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

/* bench/testbench.sv */
module testbench;
   import racu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = SEGMENTS + 8;
   localparam int RANDOM_BEATS = 185;

   typedef struct packed {
      logic              func;
      logic [LIDX_W-1:0] load_index;
      logic [LOAD_W-1:0] load_value;
      logic [STN_W-1:0]  start_station;
      logic [STN_W-1:0]  end_station;
      logic [LOAD_W-1:0] amount;
   } seat_req_type;

   // Mirror of the segment loads; predicts the grant bit of every beat.
   class admission_ledger;
      logic [LOAD_W-1:0] capacity;
      logic [LOAD_W-1:0] seg_load [SEGMENTS];
      bit                grant_queue [$];
      int                errors;
      int                granted;
      int                refused;
      int                loads_done;

      function new();
         capacity = '0;
         foreach (seg_load[i]) seg_load[i] = '0;
         errors = 0;
         granted = 0;
         refused = 0;
         loads_done = 0;
      endfunction

      function int pending();
         return grant_queue.size();
      endfunction

      function void note_request(seat_req_type r);
         int lo;
         int hi;
         int peak;
         int cap;
         bit ok;
         ok = 1'b0;
         cap = int'(capacity);
         if (r.func == FUNC_LOAD) begin
            if (int'(r.load_index) < SEGMENTS) begin
               seg_load[r.load_index] = r.load_value;
               ok = 1'b1;
            end
            loads_done++;
         end else begin
            lo = int'(r.start_station);
            hi = (int'(r.end_station) > SEGMENTS) ? SEGMENTS : int'(r.end_station);
            peak = 0;
            for (int i = lo; i < hi; i++) begin
               if (int'(seg_load[i]) > peak) peak = int'(seg_load[i]);
            end
            // a segment already over capacity refuses even a zero amount
            if (peak <= cap && cap - peak >= int'(r.amount)) begin
               for (int i = lo; i < hi; i++) seg_load[i] = seg_load[i] + r.amount;
               ok = 1'b1;
               granted++;
            end else begin
               refused++;
            end
         end
         grant_queue.push_back(ok);
      endfunction

      function void check_grant(logic got);
         bit want;
         if (grant_queue.size() == 0) begin
            errors++;
            $error("rsp_accepted: no beat pending, got %0b", got);
            return;
         end
         want = grant_queue.pop_front();
         if (got !== want) begin
            errors++;
            $error("rsp_accepted: expected %0b, got %0b", want, got);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_func;
   logic [LIDX_W-1:0] req_load_index;
   logic [LOAD_W-1:0] req_load_value;
   logic [STN_W-1:0]  req_start_station;
   logic [STN_W-1:0]  req_end_station;
   logic [LOAD_W-1:0] req_amount;
   logic              csr_wr_en;
   logic [LOAD_W-1:0] csr_wr_data;
   logic              rsp_strobe;
   logic              rsp_accepted;

   admission_ledger ledger = new();
   int cycles = 0;
   int beats = 0;
   int cap_writes = 0;

   range_capacity_admission_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_load_index    (req_load_index),
      .req_load_value    (req_load_value),
      .req_start_station (req_start_station),
      .req_end_station   (req_end_station),
      .req_amount        (req_amount),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_accepted      (rsp_accepted)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) ledger.check_grant(rsp_accepted);
   end

   function automatic seat_req_type load_beat(int idx, int val);
      seat_req_type r;
      r = '0;
      r.func = FUNC_LOAD;
      r.load_index = LIDX_W'(idx);
      r.load_value = LOAD_W'(val);
      return r;
   endfunction

   function automatic seat_req_type book_beat(int st, int en, int amt);
      seat_req_type r;
      r = '0;
      r.func = FUNC_BOOK;
      r.start_station = STN_W'(st);
      r.end_station = STN_W'(en);
      r.amount = LOAD_W'(amt);
      return r;
   endfunction

   // start is lowered only during a gap, so a back-to-back beat keeps it high
   task automatic send_beat(input seat_req_type r, input int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start             <= 1'b1;
      req_func          <= r.func;
      req_load_index    <= r.load_index;
      req_load_value    <= r.load_value;
      req_start_station <= r.start_station;
      req_end_station   <= r.end_station;
      req_amount        <= r.amount;
      do @(posedge clock); while (busy);
      ledger.note_request(r);
      beats++;
   endtask

   task automatic drain_pipe();
      @(negedge clock);
      start <= 1'b0;
      while (ledger.pending() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input int val);
      drain_pipe();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= LOAD_W'(val);
      ledger.capacity = LOAD_W'(val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cap_writes++;
   endtask

   initial begin
      int caps [6];
      int cap;
      int sel;
      int gap;
      int no_gap_run;
      seat_req_type r;

      reset             = 1'b1;
      start             = 1'b0;
      req_func          = FUNC_LOAD;
      req_load_index    = '0;
      req_load_value    = '0;
      req_start_station = '0;
      req_end_station   = '0;
      req_amount        = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      no_gap_run        = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // capacity still at its reset value of zero
      send_beat(book_beat(0, 1, 0), 0);
      send_beat(book_beat(0, 1, 1), 1);
      send_beat(load_beat(0, 0), 0);

      write_capacity(1000);
      send_beat(load_beat(63, 16'hFFFF), 0);
      send_beat(load_beat(42, 500), 2);
      send_beat(book_beat(0, 64, 0), 0);      // segment over capacity
      send_beat(book_beat(0, 63, 500), 3);
      send_beat(book_beat(42, 43, 1), 0);
      send_beat(book_beat(42, 43, 0), 0);
      send_beat(book_beat(10, 10, 1000), 1);  // empty range
      send_beat(book_beat(10, 10, 1001), 0);
      send_beat(book_beat(70, 127, 0), 0);    // clipped to nothing
      send_beat(book_beat(63, 127, 0), 2);
      send_beat(book_beat(127, 0, 5), 0);
      send_beat(load_beat(63, 0), 0);
      send_beat(book_beat(60, 127, 500), 1);
      send_beat(book_beat(0, 64, 1), 0);

      write_capacity(16'hFFFF);
      send_beat(book_beat(5, 6, 65035), 0);
      send_beat(book_beat(5, 6, 0), 0);
      send_beat(book_beat(6, 7, 16'hFFFF), 1);
      send_beat(book_beat(64, 64, 16'hFFFF), 0);
      send_beat(load_beat(1, 16'hAAAA), 0);
      send_beat(load_beat(2, 16'h5555), 0);

      caps = '{0, 16'hFFFF, 37, 1000, $urandom_range(2, 16'hFFFE), 1};
      foreach (caps[p]) begin
         cap = caps[p];
         write_capacity(cap);
         repeat (RANDOM_BEATS) begin
            r.func          = 1'($urandom_range(0, 1));
            r.load_index    = LIDX_W'($urandom);
            r.load_value    = LOAD_W'($urandom);
            r.start_station = STN_W'($urandom);
            r.end_station   = STN_W'($urandom);
            r.amount        = LOAD_W'($urandom);
            if ($urandom_range(0, 99) < 25) begin
               r.func = FUNC_LOAD;
               if ($urandom_range(0, 99) < 70) r.load_value = LOAD_W'($urandom_range(0, cap));
            end else begin
               r.func = FUNC_BOOK;
               sel = $urandom_range(0, 99);
               if (sel < 75) begin
                  r.start_station = STN_W'($urandom_range(0, SEGMENTS - 1));
                  r.end_station   =
                     STN_W'($urandom_range(int'(r.start_station) + 1, SEGMENTS));
               end else if (sel < 85) begin
                  r.start_station = STN_W'($urandom_range(0, SEGMENTS));
                  r.end_station   = STN_W'($urandom_range(SEGMENTS + 1, 127));
               end else if (sel < 95) begin
                  r.end_station   = STN_W'($urandom_range(0, 127));
                  r.start_station = STN_W'($urandom_range(int'(r.end_station), 127));
               end
               if ($urandom_range(0, 99) < 80) r.amount = LOAD_W'($urandom_range(0, cap / 6 + 1));
            end
            // occasional runs of back-to-back beats
            if (no_gap_run == 0 && $urandom_range(0, 39) == 0)
               no_gap_run = $urandom_range(10, 40);
            if (no_gap_run > 0) begin
               gap = 0;
               no_gap_run--;
            end else begin
               gap = $urandom_range(0, 15);
            end
            send_beat(r, gap);
         end
      end

      drain_pipe();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("testbench: %0d beats over %0d capacity settings, %0d segment loads",
               beats, cap_writes, ledger.loads_done);
      $display("testbench: %0d bookings granted, %0d refused, %0d mismatches",
               ledger.granted, ledger.refused, ledger.errors);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/racu_pkg.sv
hdl/racu_cell.sv
hdl/racu_ctrl.sv
hdl/range_capacity_admission_unit.sv
hdl/racu_checker.sv
bench/testbench.sv
